/* design/skeleton_pixel_rank_classifier_unit_assert.svh */
// Assertion macros shared by the skeleton pixel rank classifier.
`ifndef SKELETON_PIXEL_RANK_CLASSIFIER_UNIT_ASSERT_SVH
`define SKELETON_PIXEL_RANK_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define SPRC_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sprc assertion failed");

`define SPRC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sprc assertion failed");

`else

`define SPRC_ASSERT_ALWAYS(name, cond)

`define SPRC_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* design/sprc_pkg.sv */
package sprc_pkg;

    localparam int CFG_BITS = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] RANK_NONE = 3'd0;
    localparam logic [2:0] RANK_ENDPOINT = 3'd1;
    localparam logic [2:0] RANK_BRANCH = 3'd2;
    localparam logic [2:0] RANK_JUNCTION3 = 3'd3;
    localparam logic [2:0] RANK_JUNCTION4 = 3'd4;
    localparam logic [2:0] RANK_CROSS = 3'd5;

    localparam logic [7:0] MASK_ORTHO = 8'b01010101;
    localparam logic [7:0] MASK_TOP = 8'b01000000;
    localparam logic [7:0] MASK_LOW5 = 8'b00011111;
    localparam logic [7:0] MASK_J3_HIT = 8'b10100100;
    localparam logic [7:0] MASK_J3_MISS_A = 8'b01010001;
    localparam logic [7:0] MASK_J3_MISS_B = 8'b01001010;
    localparam logic [7:0] MASK_J3_T_HIT = 8'b00010101;
    localparam logic [7:0] MASK_DIAG = 8'b10101010;
    localparam logic [7:0] MASK_BOTTOM3 = 8'b00011100;

    typedef struct packed {
        logic [2:0] col;
        logic       first;
        logic       emit;
        logic       frame_end;
    } t_entry;

    typedef struct packed {
        logic clr_busy;
        logic s1_valid;
    } t_front_status;

    function automatic logic has_all(input logic [7:0] n, input logic [7:0] m);
        return (n & m) == m;
    endfunction

    function automatic logic has_none(input logic [7:0] n, input logic [7:0] m);
        return (n & m) == 8'd0;
    endfunction

    // Window bit index is row * 3 + column; the new column enters on the right.
    function automatic logic [8:0] shift_in(input logic [8:0] w, input logic [2:0] col);
        logic [8:0] res;
        res = 9'd0;
        for (int r = 0; r < 3; r++) begin
            res[r*3]     = w[r*3+1];
            res[r*3 + 1] = w[r*3+2];
            res[r*3 + 2] = col[r];
        end
        return res;
    endfunction

    function automatic logic [2:0] rank_of(input logic centre, input logic [7:0] n);
        logic [2:0]  res;
        logic        found;
        logic [15:0] dbl;
        logic [7:0]  rot;
        res = RANK_BRANCH;
        found = 1'b0;
        if (!centre) begin
            res = has_all(n, MASK_ORTHO) ? RANK_CROSS : RANK_NONE;
            found = 1'b1;
        end else if (n == 8'd0) begin
            res = RANK_ENDPOINT;
            found = 1'b1;
        end
        for (int s = 0; s < 8; s++) begin
            dbl = {n, n} << s;
            rot = dbl[15:8];
            if (!found) begin
                if (has_all(rot, MASK_TOP) && has_none(rot, MASK_LOW5)) begin
                    res = RANK_ENDPOINT;
                    found = 1'b1;
                end else if (has_all(rot, MASK_J3_HIT) &&
                             (has_none(rot, MASK_J3_MISS_A) ||
                              has_none(rot, MASK_J3_MISS_B))) begin
                    res = RANK_JUNCTION3;
                    found = 1'b1;
                end else if (has_all(rot, MASK_J3_T_HIT) &&
                             has_none(rot, MASK_J3_MISS_B)) begin
                    res = RANK_JUNCTION3;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            if ((has_all(n, MASK_DIAG) && has_none(n, MASK_ORTHO)) ||
                (has_all(n, MASK_ORTHO) && has_none(n, MASK_DIAG)) ||
                has_all(n, MASK_BOTTOM3)) begin
                res = RANK_JUNCTION4;
            end else begin
                res = RANK_BRANCH;
            end
        end
        return res;
    endfunction

    // Top-left neighbor is the MSB, the others follow clockwise.
    function automatic logic [2:0] classify(input logic [8:0] w);
        logic [7:0] n;
        n = {w[0], w[1], w[2], w[5], w[8], w[7], w[6], w[3]};
        return rank_of(w[4], n);
    endfunction

endpackage

/* design/sprc_front.sv */
module sprc_front
    import sprc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic                      i_pixel,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]       i_cfg_data,
    output t_entry                    o_entry,
    output logic                      o_entry_valid,
    input  logic                      i_full,
    output t_front_status             o_status
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int AW = (CW > RW) ? CW : RW;
    localparam int DW = ((AW > CFG_BITS) ? AW : CFG_BITS) + 1;
    localparam logic [DW-1:0] MAXW_D = DW'(MAX_WIDTH);
    localparam logic [DW-1:0] MAXH_D = DW'(MAX_HEIGHT);
    localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);

    logic [CFG_BITS-1:0] r_width;
    logic [CFG_BITS-1:0] r_height;
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic                r_clr_busy;
    logic [CW-1:0]       r_clr_addr;
    logic                r_s1_valid;
    logic                r_s1_pix;
    logic                r_s1_use_top;
    logic                r_s1_use_mid;
    logic                r_s1_bank;
    logic                r_s1_first;
    logic                r_s1_emit;
    logic                r_s1_fe;
    logic                r_rd0;
    logic                r_rd1;

    logic mem0 [MAX_WIDTH];
    logic mem1 [MAX_WIDTH];

    logic [DW-1:0] w_ext;
    logic [DW-1:0] h_ext;
    logic [DW-1:0] eff_w;
    logic [DW-1:0] eff_h;
    logic [DW-1:0] c_ext;
    logic [DW-1:0] r_ext;
    logic          at_col0;
    logic          close;
    logic          pix;
    logic          wrap;
    logic          accept;
    logic          emit;
    logic [CW-1:0] mem_addr;
    logic          mem_wdata;
    logic          we0;
    logic          we1;
    logic          top_bit;
    logic          mid_bit;

    always_comb begin
        w_ext = DW'(r_width);
        h_ext = DW'(r_height);
        if (w_ext == '0) begin
            eff_w = DW'(1);
        end else if (w_ext > MAXW_D) begin
            eff_w = MAXW_D;
        end else begin
            eff_w = w_ext;
        end
        if (h_ext == '0) begin
            eff_h = DW'(1);
        end else if (h_ext > MAXH_D) begin
            eff_h = MAXH_D;
        end else begin
            eff_h = h_ext;
        end
        c_ext   = DW'(r_col);
        r_ext   = DW'(r_row);
        at_col0 = (r_col == '0);
        close   = at_col0 && (r_ext >= eff_h + DW'(1));
        pix     = !i_op && i_pixel && (r_ext < eff_h) && !close;
        wrap    = (c_ext + DW'(1)) >= eff_w;
        if (close) begin
            emit = (r_ext == eff_h + DW'(1));
        end else if (at_col0) begin
            emit = (r_ext >= DW'(2));
        end else begin
            emit = (r_ext >= DW'(1));
        end
    end

    assign o_ready = !r_clr_busy && (!r_s1_valid || !i_full);
    assign accept  = i_valid && o_ready;

    assign mem_addr  = r_clr_busy ? r_clr_addr : r_col;
    assign mem_wdata = r_clr_busy ? 1'b0 : pix;
    assign we0       = r_clr_busy || (accept && !close && !r_row[0]);
    assign we1       = r_clr_busy || (accept && !close && r_row[0]);

    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[mem_addr] <= mem_wdata;
        end
        if (accept) begin
            r_rd0 <= mem0[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[mem_addr] <= mem_wdata;
        end
        if (accept) begin
            r_rd1 <= mem1[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_RESET;
            r_height <= CFG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end else if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_COL) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (close) begin
                r_col <= '0;
                r_row <= '0;
            end else if (wrap) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (!i_full) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix     <= pix;
            r_s1_use_top <= !close && (r_ext >= DW'(2));
            r_s1_use_mid <= !close && (r_ext >= DW'(1));
            r_s1_bank    <= r_row[0];
            r_s1_first   <= at_col0;
            r_s1_emit    <= emit;
            r_s1_fe      <= close;
        end
    end

    assign top_bit = r_s1_bank ? r_rd1 : r_rd0;
    assign mid_bit = r_s1_bank ? r_rd0 : r_rd1;

    assign o_entry.col       = {r_s1_pix, r_s1_use_mid & mid_bit, r_s1_use_top & top_bit};
    assign o_entry.first     = r_s1_first;
    assign o_entry.emit      = r_s1_emit;
    assign o_entry.frame_end = r_s1_fe;
    assign o_entry_valid     = r_s1_valid;

    assign o_status.clr_busy = r_clr_busy;
    assign o_status.s1_valid = r_s1_valid;

endmodule

/* design/sprc_queue.sv */
module sprc_queue
    import sprc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW:0] FULL_COUNT = (PW + 1)'(QUEUE_DEPTH);

    t_entry        r_slots [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW + 1)'(1);
            end
        end
    end

endmodule

/* design/sprc_back.sv */
module sprc_back
    import sprc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_entry,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_rank,
    output logic       o_frame_end
);

    logic [8:0] r_win;
    logic       r_out_valid;
    logic [2:0] r_rank;
    logic       r_fe;

    logic [8:0] shifted_new;
    logic [8:0] shifted_zero;
    logic [8:0] row_start;
    logic [8:0] cls_win;
    logic [8:0] n_win;
    logic [2:0] rank;

    always_comb begin
        shifted_new  = shift_in(r_win, i_entry.col);
        shifted_zero = shift_in(r_win, 3'b000);
        row_start    = shift_in(9'd0, i_entry.col);
        cls_win      = i_entry.first ? shifted_zero : shifted_new;
        n_win        = i_entry.first ? row_start : shifted_new;
        rank         = classify(cls_win);
    end

    assign o_pop = !i_empty && (!i_entry.emit || !r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_win <= n_win;
            end
            if (o_pop && i_entry.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.emit) begin
            r_rank <= rank;
            r_fe   <= i_entry.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_rank      = r_rank;
    assign o_frame_end = r_fe;

endmodule

/* design/skeleton_pixel_rank_classifier_unit.sv */
// Ranks each pixel of a binary skeleton image that arrives in raster order, one word per
// clock while the line banks are not being cleared and the queue has room, as none, endpoint,
// branch, 3-way junction, 4-way junction or hollow cross. Results lag the input by one row
// plus one pixel; drain words push out the last row, and the first column-0 word of row
// height+1 returns the frame's last result with frame_end set and restarts the frame. The
// front end reads and writes the two line banks in the cycle a word is accepted and hands
// the neighbor column to the back end through a four-word queue; the back end shifts the
// 3x3 window and classifies combinationally into the output register. After reset the line
// banks are cleared while no word is accepted; configuration writes are taken at any time.
`include "skeleton_pixel_rank_classifier_unit_assert.svh"

module skeleton_pixel_rank_classifier_unit
    import sprc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic                      i_pixel,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_rank,
    output logic                      o_frame_end,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]       i_cfg_data
);

    t_entry        front_entry;
    logic          front_valid;
    t_front_status front_status;
    logic          q_full;
    logic          q_empty;
    t_entry        q_entry;
    logic          q_pop;

    sprc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_pixel       (i_pixel),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_entry       (front_entry),
        .o_entry_valid (front_valid),
        .i_full        (q_full),
        .o_status      (front_status)
    );

    sprc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_empty (q_empty)
    );

    sprc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (q_entry),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rank      (o_rank),
        .o_frame_end (o_frame_end)
    );

    `SPRC_ASSERT_ALWAYS(a_no_accept_in_clear, !(front_status.clr_busy && i_valid && o_ready))
    `SPRC_ASSERT_NEXT(a_accept_fills_stage, i_valid && o_ready, front_status.s1_valid)
    `SPRC_ASSERT_ALWAYS(a_rank_legal, !o_valid || (o_rank <= RANK_CROSS))

endmodule

/* verif/skeleton_pixel_rank_classifier_unit_tb.sv */
`timescale 1ns / 1ps

module skeleton_pixel_rank_classifier_unit_tb;
    import sprc_pkg::*;

    localparam int LINE_MAX = 1024;
    localparam int ROWS_MAX = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS = 180;
    localparam int IDLE_PCT = 31;
    localparam int WIDE_CUT = 1040;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
    localparam logic [8:0] CROSS_IMAGE = 9'b010_101_010;

    typedef struct packed {
        logic op;
        logic pixel;
    } t_pixel_word;

    typedef struct packed {
        logic [2:0] rank;
        logic       frame_end;
    } t_rank_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_op;
    logic                      i_pixel;
    logic                      o_valid;
    logic                      i_ready;
    logic [2:0]                o_rank;
    logic                      o_frame_end;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]       i_cfg_data;

    t_pixel_word pixel_words_pending[$];
    t_rank_word  ranks_due[$];
    t_pixel_word word_out;
    t_rank_word  due_word;

    logic [CFG_BITS-1:0] width_setting;
    logic [CFG_BITS-1:0] height_setting;
    logic                line_bank [2][LINE_MAX];
    logic [8:0]          window_bits;
    int unsigned         row_pos;
    int unsigned         col_pos;

    bit word_taken = 1'b0;
    bit steady = 1'b0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int words_fed = 0;

    skeleton_pixel_rank_classifier_unit #(
        .MAX_WIDTH (LINE_MAX),
        .MAX_HEIGHT(ROWS_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_pixel    (i_pixel),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rank     (o_rank),
        .o_frame_end(o_frame_end),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_pending(input t_pixel_word w);
        pixel_words_pending = {pixel_words_pending, w};
    endfunction

    function automatic void add_due(input t_rank_word w);
        ranks_due = {ranks_due, w};
    endfunction

    function automatic int unsigned clamp_dim(input logic [CFG_BITS-1:0] v, input int unsigned top);
        if (v == '0) begin
            return 1;
        end
        if (v > top) begin
            return top;
        end
        return 32'(v);
    endfunction

    // The new column enters on the right of each window row; bit 0 of col is the top row.
    function automatic logic [8:0] window_push(input logic [8:0] win, input logic [2:0] col);
        return {col[2], win[8:7], col[1], win[5:4], col[0], win[2:1]};
    endfunction

    function automatic logic [2:0] pixel_rank(input logic [8:0] win);
        logic [7:0] ring;
        logic [7:0] rot;
        int         s;
        ring = {win[0], win[1], win[2], win[5], win[8], win[7], win[6], win[3]};
        if (!win[4]) begin
            return ((ring & MASK_ORTHO) == MASK_ORTHO) ? RANK_CROSS : RANK_NONE;
        end
        if (ring == 8'd0) begin
            return RANK_ENDPOINT;
        end
        for (s = 0; s < 8; s++) begin
            rot = (ring << s) | (ring >> (8 - s));
            if ((rot & MASK_TOP) == MASK_TOP && (rot & MASK_LOW5) == 8'd0) begin
                return RANK_ENDPOINT;
            end
            if ((rot & MASK_J3_HIT) == MASK_J3_HIT &&
                ((rot & MASK_J3_MISS_A) == 8'd0 || (rot & MASK_J3_MISS_B) == 8'd0)) begin
                return RANK_JUNCTION3;
            end
            if ((rot & MASK_J3_T_HIT) == MASK_J3_T_HIT && (rot & MASK_J3_MISS_B) == 8'd0) begin
                return RANK_JUNCTION3;
            end
        end
        if (((ring & MASK_DIAG) == MASK_DIAG && (ring & MASK_ORTHO) == 8'd0) ||
            ((ring & MASK_ORTHO) == MASK_ORTHO && (ring & MASK_DIAG) == 8'd0) ||
            (ring & MASK_BOTTOM3) == MASK_BOTTOM3) begin
            return RANK_JUNCTION4;
        end
        return RANK_BRANCH;
    endfunction

    task automatic take_pixel_word(input logic op, input logic pixel);
        int unsigned wd;
        int unsigned ht;
        int unsigned r;
        int unsigned c;
        logic        p;
        logic        top;
        logic        mid;
        t_rank_word  due;
        wd = clamp_dim(width_setting, LINE_MAX);
        ht = clamp_dim(height_setting, ROWS_MAX);
        r = row_pos;
        c = col_pos;
        if (c >= LINE_MAX) begin
            c = 0;
        end
        // Column 0 past the last drain row closes the frame; only row height+1 reports.
        if (c == 0 && r >= ht + 1) begin
            if (r == ht + 1) begin
                due.rank = pixel_rank(window_push(window_bits, 3'b000));
                due.frame_end = 1'b1;
                add_due(due);
            end
            window_bits = '0;
            col_pos = 0;
            row_pos = 0;
            return;
        end
        p = !op && pixel && (r < ht);
        top = (r >= 2) ? line_bank[r & 1][c] : 1'b0;
        mid = (r >= 1) ? line_bank[(r + 1) & 1][c] : 1'b0;
        line_bank[r & 1][c] = p;
        due.frame_end = 1'b0;
        if (c == 0) begin
            if (r >= 2) begin
                due.rank = pixel_rank(window_push(window_bits, 3'b000));
                add_due(due);
            end
            window_bits = window_push(9'd0, {p, mid, top});
        end else begin
            window_bits = window_push(window_bits, {p, mid, top});
            if (r >= 1) begin
                due.rank = pixel_rank(window_bits);
                add_due(due);
            end
        end
        if (c + 1 >= wd) begin
            col_pos = 0;
            row_pos = (r + 1) & 11'h7FF;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic settle();
        while (pixel_words_pending.size() != 0 || i_valid || ranks_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        if (idx == REG_IMAGE_WIDTH) begin
            width_setting = value;
        end else if (idx == REG_IMAGE_HEIGHT) begin
            height_setting = value;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Walks the frame position from where the block stands now, so a cut frame is
    // finished under the new size. A negative cut sends everything up to the frame close.
    task automatic feed_frame(input int cut_at, input int density, input int noise);
        int unsigned wd;
        int unsigned ht;
        int unsigned r;
        int unsigned c;
        int          count;
        bit          closing;
        t_pixel_word word;
        wd = clamp_dim(width_setting, LINE_MAX);
        ht = clamp_dim(height_setting, ROWS_MAX);
        r = row_pos;
        c = col_pos;
        count = 0;
        closing = 1'b0;
        while (!closing && count != cut_at) begin
            if (c >= LINE_MAX) begin
                c = 0;
            end
            closing = (c == 0 && r >= ht + 1);
            if (r < ht) begin
                word.op = ($urandom_range(0, 99) < noise);
                word.pixel = ($urandom_range(0, 99) < density);
            end else begin
                word.op = ($urandom_range(0, 99) >= noise);
                word.pixel = 1'($urandom_range(0, 1));
            end
            add_pending(word);
            count++;
            if (c + 1 >= wd) begin
                c = 0;
                r = (r + 1) & 11'h7FF;
            end else begin
                c++;
            end
        end
        words_fed += count;
        settle();
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        word_taken = i_rst_n && i_valid && o_ready;
        if (word_taken) begin
            take_pixel_word(i_op, i_pixel);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (ranks_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected rank word: rank %0d frame_end %0d", o_rank, o_frame_end);
                end
            end else begin
                due_word = ranks_due.pop_front();
                if (o_rank !== due_word.rank || o_frame_end !== due_word.frame_end) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("rank word mismatch: expected %0d/%0d, got %0d/%0d",
                                 due_word.rank, due_word.frame_end, o_rank, o_frame_end);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_taken) begin
            if (pixel_words_pending.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                word_out = pixel_words_pending.pop_front();
                i_valid <= 1'b1;
                i_op <= word_out.op;
                i_pixel <= word_out.pixel;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int i;
        int phase;
        int wd;
        int ht;
        int start_fed;
        bit after_cut;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = 1'b0;
        i_pixel = 1'b0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        width_setting = CFG_RESET;
        height_setting = CFG_RESET;
        window_bits = '0;
        row_pos = 0;
        col_pos = 0;
        for (i = 0; i < LINE_MAX; i++) begin
            line_bank[0][i] = 1'b0;
            line_bank[1][i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A lone pixel in a one-pixel image; drain and close words carry set bits that must be ignored.
        set_reg(REG_IMAGE_WIDTH, 11'd1);
        set_reg(REG_IMAGE_HEIGHT, 11'd1);
        add_pending({1'b0, 1'b1});
        add_pending({1'b1, 1'b1});
        add_pending({1'b0, 1'b1});
        settle();
        set_reg(REG_SPARE_A, CFG_BITS'($urandom));
        set_reg(REG_SPARE_B, 11'h7FF);

        // Hollow cross around a center word sent as a drain word with its pixel set.
        set_reg(REG_IMAGE_WIDTH, 11'd3);
        set_reg(REG_IMAGE_HEIGHT, 11'd3);
        for (i = 0; i < 9; i++) begin
            add_pending({i == 4, (i == 4) ? 1'b1 : CROSS_IMAGE[8 - i]});
        end
        for (i = 0; i < 3; i++) begin
            add_pending({1'b1, i[0]});
        end
        add_pending({1'b0, 1'b1});
        settle();

        // A solid two-row block; the drain row is sent as image words that count as zero.
        set_reg(REG_IMAGE_HEIGHT, 11'd2);
        for (i = 0; i < 10; i++) begin
            add_pending({1'b0, 1'b1});
        end
        settle();

        after_cut = 1'b0;
        phase = 0;
        start_fed = words_fed;
        while (words_fed - start_fed < RANDOM_WORDS) begin
            wd = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            ht = after_cut ? $urandom_range(1, 4) : $urandom_range(1, 10);
            steady = (phase >= 2 && phase < 5);
            if ($urandom_range(0, 7) == 0) begin
                set_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_BITS'($urandom));
            end
            set_reg(REG_IMAGE_WIDTH, CFG_BITS'(wd));
            set_reg(REG_IMAGE_HEIGHT, CFG_BITS'(ht));
            after_cut = ($urandom_range(0, 5) == 0);
            feed_frame(after_cut ? $urandom_range(1, (ht + 1) * wd) : -1,
                       $urandom_range(15, 75), $urandom_range(0, 8));
            phase++;
        end

        // A row wider than the line store wraps at the store width; the frame is cut past the wrap.
        steady = 1'b1;
        set_reg(REG_IMAGE_WIDTH, 11'h7FF);
        set_reg(REG_IMAGE_HEIGHT, 11'd0);
        feed_frame(WIDE_CUT, 35, 2);
        steady = 1'b0;
        set_reg(REG_IMAGE_WIDTH, 11'd0);
        set_reg(REG_IMAGE_HEIGHT, 11'd3);
        feed_frame(-1, 50, 4);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
